FILE: src/gpmt_pkg.sv
// shared types, constants and helpers for the greedy path-merge tour builder
// used by every module of the block; no dependencies
package gpmt_pkg;

    localparam int MAX_POINTS = 64;
    localparam int COORD_BITS = 16;
    localparam int IDX_W      = $clog2(MAX_POINTS + 1);
    localparam int CNT_W      = $clog2(MAX_POINTS);
    localparam int SQ_W       = 2 * COORD_BITS;
    localparam int LEN_W      = SQ_W + 1;
    localparam int DEG_W      = 2;
    localparam int S_DATA_W   = 32;
    localparam int M_DATA_W   = 48;
    localparam int M_USER_W   = 3;

    typedef logic [IDX_W-1:0] idx_t;
    typedef logic signed [COORD_BITS-1:0] coord_t;

    typedef enum logic [1:0] {
        PH_NEAREST = 2'd0,
        PH_JOIN    = 2'd1,
        PH_CLOSE   = 2'd2
    } phase_t;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_PROBE,
        ST_ROT,
        ST_DRAIN,
        ST_REDUCE,
        ST_DECIDE
    } state_t;

    // point that travels around the ring of cells
    typedef struct packed {
        idx_t             idx;
        coord_t           x;
        coord_t           y;
        logic [DEG_W-1:0] deg;
        idx_t             label;
    } probe_t;

    // best pair seen so far, with the path labels of both ends
    typedef struct packed {
        logic             found;
        logic [LEN_W-1:0] len;
        idx_t             i;
        idx_t             j;
        idx_t             li;
        idx_t             lj;
    } best_t;

    typedef struct packed {
        logic   clear;
        logic   wr;
        idx_t   wr_idx;
        coord_t wr_x;
        coord_t wr_y;
        logic   load_probe;
        logic   shift;
        logic   eval;
        logic   reduce;
        logic   link;
        phase_t phase;
        idx_t   n;
        idx_t   bi;
        idx_t   bj;
        idx_t   li;
        idx_t   lj;
    } cell_ctl_t;

    // shorter length wins, ties go to lower i then lower j
    function automatic logic best_less(input best_t a, input best_t b);
        logic r;
        r = a.found && (!b.found || (a.len < b.len) ||
            ((a.len == b.len) && ((a.i < b.i) || ((a.i == b.i) && (a.j < b.j)))));
        return r;
    endfunction

endpackage

FILE: src/gpmt_cell.sv
// one cell of the ring: holds one point, its degree and path label,
// checks the passing probe point and keeps the best pair; uses gpmt_pkg
module gpmt_cell (
    input  logic               aclk,
    input  logic               aresetn,
    input  gpmt_pkg::idx_t     own_idx,
    input  gpmt_pkg::cell_ctl_t ctl,
    input  gpmt_pkg::probe_t   probe_in,
    input  gpmt_pkg::best_t    best_in,
    output gpmt_pkg::probe_t   probe_out,
    output gpmt_pkg::best_t    best_out
);
    import gpmt_pkg::*;

    coord_t           x_reg, y_reg;
    logic [DEG_W-1:0] deg_reg, deg_next;
    idx_t             label_reg, label_next;
    probe_t           probe_reg, own_probe;
    best_t            best_reg, best_next, cand;
    logic [SQ_W-1:0]  sqx_reg, sqy_reg;
    logic             a_ok_reg, ok;
    idx_t             a_i_reg, a_li_reg;
    logic             active;
    logic signed [COORD_BITS:0] dx, dy;
    logic [COORD_BITS-1:0] adx, ady;

    assign active = own_idx <= ctl.n;

    always_comb begin
        own_probe       = '0;
        own_probe.idx   = active ? own_idx : '0;
        own_probe.x     = x_reg;
        own_probe.y     = y_reg;
        own_probe.deg   = deg_reg;
        own_probe.label = label_reg;
    end

    assign dx  = {x_reg[COORD_BITS-1], x_reg} - {probe_reg.x[COORD_BITS-1], probe_reg.x};
    assign dy  = {y_reg[COORD_BITS-1], y_reg} - {probe_reg.y[COORD_BITS-1], probe_reg.y};
    assign adx = dx[COORD_BITS] ? COORD_BITS'(-dx) : dx[COORD_BITS-1:0];
    assign ady = dy[COORD_BITS] ? COORD_BITS'(-dy) : dy[COORD_BITS-1:0];

    // the probe is the lower-numbered end of the pair
    always_comb begin
        ok = 1'b0;
        if (active && (probe_reg.idx != '0) && (probe_reg.idx < own_idx)) begin
            case (ctl.phase)
                PH_NEAREST: ok = (probe_reg.deg == 2'd0) && (deg_reg <= 2'd1);
                PH_JOIN:    ok = (probe_reg.deg == 2'd1) && (deg_reg == 2'd1) &&
                                 (probe_reg.label != label_reg);
                PH_CLOSE:   ok = (probe_reg.deg == 2'd1) && (deg_reg == 2'd1) &&
                                 (probe_reg.label == label_reg);
                default:    ok = 1'b0;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        sqx_reg  <= adx * adx;
        sqy_reg  <= ady * ady;
        a_i_reg  <= probe_reg.idx;
        a_li_reg <= probe_reg.label;
        if (!aresetn) begin
            a_ok_reg <= 1'b0;
        end else begin
            a_ok_reg <= ctl.eval && ok;
        end
    end

    always_comb begin
        cand.found = a_ok_reg;
        cand.len   = {1'b0, sqx_reg} + {1'b0, sqy_reg};
        cand.i     = a_i_reg;
        cand.j     = own_idx;
        cand.li    = a_li_reg;
        cand.lj    = label_reg;
    end

    always_comb begin
        best_next = best_reg;
        if (ctl.load_probe) begin
            best_next.found = 1'b0;
        end else if (best_less(cand, best_reg)) begin
            best_next = cand;
        end else if (ctl.reduce && best_less(best_in, best_reg)) begin
            best_next = best_in;
        end
    end

    always_comb begin
        deg_next   = deg_reg;
        label_next = label_reg;
        if (ctl.clear) begin
            deg_next   = '0;
            label_next = own_idx;
        end else if (ctl.link) begin
            if ((own_idx == ctl.bi) || (own_idx == ctl.bj)) begin
                deg_next = deg_reg + 2'd1;
            end
            if (label_reg == ctl.lj) begin
                label_next = ctl.li;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.wr && (ctl.wr_idx == own_idx)) begin
            x_reg <= ctl.wr_x;
            y_reg <= ctl.wr_y;
        end
        if (ctl.load_probe) begin
            probe_reg <= own_probe;
        end else if (ctl.shift) begin
            probe_reg <= probe_in;
        end
        if (!aresetn) begin
            deg_reg        <= '0;
            label_reg      <= own_idx;
            best_reg.found <= 1'b0;
        end else begin
            deg_reg   <= deg_next;
            label_reg <= label_next;
            best_reg  <= best_next;
        end
    end

    assign probe_out = probe_reg;
    assign best_out  = best_reg;

endmodule

FILE: src/gpmt_ctrl.sv
// sequencer: point loading, search rounds over the ring, edge output register
// uses gpmt_pkg
module gpmt_ctrl (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [gpmt_pkg::S_DATA_W-1:0] s_tdata,
    input  logic                          s_tlast,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [gpmt_pkg::M_DATA_W-1:0] m_tdata,
    output logic [gpmt_pkg::M_USER_W-1:0] m_tuser,
    output logic                          m_tlast,
    output gpmt_pkg::cell_ctl_t           ctl,
    input  gpmt_pkg::best_t               best_last
);
    import gpmt_pkg::*;

    state_t     state_reg, state_next;
    phase_t     phase_reg, phase_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    idx_t       count_reg, count_next;
    logic       m_valid_reg, m_valid_next;
    idx_t       m_first_reg, m_second_reg;
    logic [LEN_W-1:0] m_len_reg;
    phase_t     m_phase_reg;
    logic       m_edge_reg, m_last_reg;
    logic       load_out, out_free, s_fire;

    assign s_tready = (state_reg == ST_LOAD);
    assign s_fire   = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;

    always_comb begin
        state_next   = state_reg;
        phase_next   = phase_reg;
        cnt_next     = cnt_reg;
        count_next   = count_reg;
        m_valid_next = m_valid_reg && !m_tready;
        load_out     = 1'b0;
        ctl          = '0;
        ctl.phase    = phase_reg;
        ctl.n        = count_reg;
        ctl.wr_idx   = count_reg + idx_t'(1);
        ctl.wr_x     = s_tdata[COORD_BITS-1:0];
        ctl.wr_y     = s_tdata[16 +: COORD_BITS];
        ctl.bi       = best_last.i;
        ctl.bj       = best_last.j;
        ctl.li       = best_last.li;
        ctl.lj       = best_last.lj;
        case (state_reg)
            ST_LOAD: begin
                if (s_fire) begin
                    if (count_reg < idx_t'(MAX_POINTS)) begin
                        ctl.wr     = 1'b1;
                        count_next = count_reg + idx_t'(1);
                    end
                    if (s_tlast) begin
                        phase_next = PH_NEAREST;
                        state_next = ST_PROBE;
                    end
                end
            end
            ST_PROBE: begin
                ctl.load_probe = 1'b1;
                cnt_next       = '0;
                state_next     = ST_ROT;
            end
            ST_ROT: begin
                ctl.eval  = 1'b1;
                ctl.shift = 1'b1;
                cnt_next  = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(MAX_POINTS - 1)) begin
                    cnt_next   = '0;
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                // let the square and compare stages drain
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(1)) begin
                    cnt_next   = '0;
                    state_next = ST_REDUCE;
                end
            end
            ST_REDUCE: begin
                ctl.reduce = 1'b1;
                cnt_next   = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(MAX_POINTS - 2)) begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                if (out_free) begin
                    if (phase_reg == PH_CLOSE) begin
                        load_out     = 1'b1;
                        m_valid_next = 1'b1;
                        ctl.clear    = 1'b1;
                        count_next   = '0;
                        state_next   = ST_LOAD;
                    end else if (best_last.found) begin
                        load_out     = 1'b1;
                        m_valid_next = 1'b1;
                        ctl.link     = 1'b1;
                        state_next   = ST_PROBE;
                    end else begin
                        phase_next = (phase_reg == PH_NEAREST) ? PH_JOIN : PH_CLOSE;
                        state_next = ST_PROBE;
                    end
                end
            end
            default: begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_LOAD;
            phase_reg   <= PH_NEAREST;
            cnt_reg     <= '0;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            phase_reg   <= phase_next;
            cnt_reg     <= cnt_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
        if (load_out) begin
            m_first_reg  <= best_last.found ? best_last.i : '0;
            m_second_reg <= best_last.found ? best_last.j : '0;
            m_len_reg    <= best_last.found ? best_last.len : '0;
            m_phase_reg  <= phase_reg;
            m_edge_reg   <= best_last.found;
            m_last_reg   <= (phase_reg == PH_CLOSE);
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {(M_DATA_W - 2 * IDX_W - LEN_W)'(0), m_len_reg, m_second_reg, m_first_reg};
    assign m_tuser  = {m_edge_reg, m_phase_reg};
    assign m_tlast  = m_last_reg;

endmodule

FILE: src/greedy_path_merge_tour.sv
// top level of the greedy path-merge tour builder: sequencer plus ring of cells
// uses gpmt_pkg, gpmt_ctrl and gpmt_cell
//
// Points stream in one per cycle and are numbered 1, 2, ... in arrival order; up to 64
// are kept, further points are dropped. The transfer with tlast set starts tour
// building, during which s_tready is low. In each search round every stored point travels
// once around the ring of 64 cells, each cell rating the pair it forms with the passing
// point, then the best pair ripples down the chain to the last cell. One round runs per
// emitted edge plus one per phase change, and a stalled output holds the next round back.
// Edges come out in order with their squared length; the tour ends with the closing
// edge (or an edge_valid 0 record for a single point) marked by m_tlast.
module greedy_path_merge_tour (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [gpmt_pkg::S_DATA_W-1:0] s_tdata,  // point_x, point_y
    input  logic                          s_tlast,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [gpmt_pkg::M_DATA_W-1:0] m_tdata,  // first_node, second_node, squared_length
    output logic [gpmt_pkg::M_USER_W-1:0] m_tuser,  // edge_phase, edge_valid
    output logic                          m_tlast
);
    import gpmt_pkg::*;

    cell_ctl_t ctl;
    probe_t    probe_w [MAX_POINTS];
    best_t     best_w  [MAX_POINTS];

    gpmt_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .ctl       (ctl),
        .best_last (best_w[MAX_POINTS-1])
    );

    for (genvar k = 0; k < MAX_POINTS; k++) begin : g_cell
        if (k == 0) begin : g_head
            gpmt_cell u_cell (
                .aclk      (aclk),
                .aresetn   (aresetn),
                .own_idx   (IDX_W'(k + 1)),
                .ctl       (ctl),
                .probe_in  (probe_w[MAX_POINTS-1]),
                .best_in   (best_w[0]),
                .probe_out (probe_w[k]),
                .best_out  (best_w[k])
            );
        end else begin : g_body
            gpmt_cell u_cell (
                .aclk      (aclk),
                .aresetn   (aresetn),
                .own_idx   (IDX_W'(k + 1)),
                .ctl       (ctl),
                .probe_in  (probe_w[k-1]),
                .best_in   (best_w[k-1]),
                .probe_out (probe_w[k]),
                .best_out  (best_w[k])
            );
        end
    end

endmodule

FILE: src/gpmt_checker.sv
// port-level checks for greedy_path_merge_tour, bound to the top level
// uses gpmt_pkg widths
module gpmt_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [gpmt_pkg::M_DATA_W-1:0] m_tdata,
    input logic [gpmt_pkg::M_USER_W-1:0] m_tuser,
    input logic                          m_tlast
);
    import gpmt_pkg::*;

    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    a_hold_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // input reopens only while the final result of a tour is presented
    a_reopen: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) && $rose(s_tready) |-> m_tvalid && m_tlast)
        else $error("input reopened without closing result");

    a_close_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (!m_tuser[2] || (m_tuser[1:0] == PH_CLOSE)) |-> m_tlast)
        else $error("closing or empty result not marked last");

endmodule

bind greedy_path_merge_tour gpmt_checker u_gpmt_checker (.*);

FILE: test/greedy_path_merge_tour_chk.sv
// scoreboard for the greedy path-merge tour builder: predicts every tour edge and checks m_*
// depends on gpmt_pkg; instantiated next to the block by greedy_path_merge_tour_tb
module greedy_path_merge_tour_chk (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    input  logic                          s_tready,
    input  logic [gpmt_pkg::S_DATA_W-1:0] s_tdata,
    input  logic                          s_tlast,
    input  logic                          m_tvalid,
    input  logic                          m_tready,
    input  logic [gpmt_pkg::M_DATA_W-1:0] m_tdata,
    input  logic [gpmt_pkg::M_USER_W-1:0] m_tuser,
    input  logic                          m_tlast,
    output int                            fail_count,
    output int                            pending,
    output int                            edges_seen,
    output int                            tours_built
);
    import gpmt_pkg::*;

    typedef struct {
        logic [6:0]       first_node;
        logic [6:0]       second_node;
        logic [LEN_W-1:0] sq_len;
        phase_t           phase;
        logic             valid;
        logic             last;
    } tour_edge_t;

    tour_edge_t  edge_q[$];
    longint      pt_x [MAX_POINTS+1];
    longint      pt_y [MAX_POINTS+1];
    int          nbr_a[MAX_POINTS+1];
    int          nbr_b[MAX_POINTS+1];
    int          pt_count;

    function automatic logic [LEN_W-1:0] pair_len(int a, int b);
        longint dx;
        longint dy;
        dx = pt_x[a] - pt_x[b];
        dy = pt_y[a] - pt_y[b];
        return LEN_W'(dx * dx + dy * dy);
    endfunction

    function automatic int deg_of(int p);
        return int'(nbr_a[p] != 0) + int'(nbr_b[p] != 0);
    endfunction

    function automatic void attach(int p, int q);
        if (nbr_a[p] == 0) begin
            nbr_a[p] = q;
        end else if (nbr_b[p] == 0) begin
            nbr_b[p] = q;
        end
    endfunction

    // walk from a along its path and see whether b lies on it
    function automatic logic on_same_path(int a, int b);
        int prev;
        int cur;
        int nxt;
        prev = 0;
        cur  = a;
        for (int s = 0; s <= MAX_POINTS; s++) begin
            if (cur == b) return 1'b1;
            nxt = nbr_a[cur];
            if (nxt == prev) nxt = nbr_b[cur];
            if (nxt == 0 || nxt > MAX_POINTS) return 1'b0;
            prev = cur;
            cur  = nxt;
        end
        return 1'b0;
    endfunction

    function automatic void add_edge(int a, int b, logic [LEN_W-1:0] len, phase_t ph, logic v);
        tour_edge_t e;
        e.first_node  = 7'(a);
        e.second_node = 7'(b);
        e.sq_len      = len;
        e.phase       = ph;
        e.valid       = v;
        e.last        = 1'b0;
        edge_q.insert(edge_q.size(), e);
    endfunction

    function automatic void build_tour();
        int               n;
        int               k;
        int               bi;
        int               bj;
        logic             found;
        logic             ok;
        logic [LEN_W-1:0] best;
        logic [LEN_W-1:0] d;
        phase_t           ph;
        n  = pt_count;
        k  = 0;
        bi = 0;
        bj = 0;
        for (int p = 0; p < 2; p++) begin
            ph = (p == 0) ? PH_NEAREST : PH_JOIN;
            while (1) begin
                found = 1'b0;
                best  = '0;
                for (int i = 1; i < n; i++) begin
                    for (int j = i + 1; j <= n; j++) begin
                        if (p == 0) ok = deg_of(i) == 0 && deg_of(j) <= 1;
                        else ok = deg_of(i) == 1 && deg_of(j) == 1 && !on_same_path(i, j);
                        if (ok) begin
                            d = pair_len(i, j);
                            if (!found || d < best) begin
                                found = 1'b1;
                                best  = d;
                                bi    = i;
                                bj    = j;
                            end
                        end
                    end
                end
                if (!found || k >= MAX_POINTS) break;
                attach(bi, bj);
                attach(bj, bi);
                add_edge(bi, bj, best, ph, 1'b1);
                k++;
            end
        end
        // closing edge: the last endpoint pair in scan order on one path
        found = 1'b0;
        for (int i = 1; i < n; i++) begin
            for (int j = i + 1; j <= n; j++) begin
                if (deg_of(i) == 1 && deg_of(j) == 1 && on_same_path(i, j)) begin
                    found = 1'b1;
                    bi    = i;
                    bj    = j;
                end
            end
        end
        if (k >= MAX_POINTS) void'(edge_q.pop_back());
        if (found) begin
            attach(bi, bj);
            attach(bj, bi);
            add_edge(bi, bj, pair_len(bi, bj), PH_CLOSE, 1'b1);
        end else begin
            add_edge(0, 0, '0, PH_CLOSE, 1'b0);
        end
        edge_q[$].last = 1'b1;
        for (int p = 0; p <= MAX_POINTS; p++) begin
            nbr_a[p] = 0;
            nbr_b[p] = 0;
        end
        pt_count = 0;
    endfunction

    initial begin
        fail_count  = 0;
        pending     = 0;
        edges_seen  = 0;
        tours_built = 0;
        pt_count    = 0;
        for (int p = 0; p <= MAX_POINTS; p++) begin
            nbr_a[p] = 0;
            nbr_b[p] = 0;
            pt_x[p]  = 0;
            pt_y[p]  = 0;
        end
    end

    always @(posedge aclk) begin
        tour_edge_t exp_e;
        logic [6:0] got_a;
        logic [6:0] got_b;
        logic [LEN_W-1:0] got_len;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                if (pt_count < MAX_POINTS) begin
                    pt_count++;
                    pt_x[pt_count] = longint'($signed(s_tdata[15:0]));
                    pt_y[pt_count] = longint'($signed(s_tdata[31:16]));
                end
                if (s_tlast) begin
                    build_tour();
                    tours_built++;
                end
            end
            if (m_tvalid && m_tready) begin
                edges_seen++;
                got_a   = m_tdata[6:0];
                got_b   = m_tdata[13:7];
                got_len = m_tdata[14 +: LEN_W];
                if (edge_q.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("edge %0d: unexpected transfer %0d-%0d len %0d",
                                 edges_seen, got_a, got_b, got_len);
                end else begin
                    exp_e = edge_q.pop_front();
                    if (got_a !== exp_e.first_node || got_b !== exp_e.second_node ||
                        got_len !== exp_e.sq_len || m_tuser[1:0] !== exp_e.phase ||
                        m_tuser[2] !== exp_e.valid || m_tlast !== exp_e.last) begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display({"edge %0d: exp %0d-%0d len %0d ph %0d v %0b l %0b, ",
                                      "got %0d-%0d len %0d ph %0d v %0b l %0b"},
                                     edges_seen, exp_e.first_node, exp_e.second_node,
                                     exp_e.sq_len, exp_e.phase, exp_e.valid, exp_e.last,
                                     got_a, got_b, got_len, m_tuser[1:0], m_tuser[2],
                                     m_tlast);
                    end
                end
            end
        end
        pending = edge_q.size();
    end

endmodule

FILE: test/greedy_path_merge_tour_tb.sv
// top of the testbench for the greedy path-merge tour builder: clock, reset, stimulus, verdict
// depends on gpmt_pkg, greedy_path_merge_tour and greedy_path_merge_tour_chk
module greedy_path_merge_tour_tb;
    import gpmt_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int LONG_HOLD   = 3000;

    logic                aclk;
    logic                aresetn;
    logic                s_tvalid;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata;   // point_x, point_y
    logic                s_tlast;
    logic                m_tvalid;
    logic                m_tready;
    logic [M_DATA_W-1:0] m_tdata;   // first_node, second_node, squared_length
    logic [M_USER_W-1:0] m_tuser;   // edge_phase, edge_valid
    logic                m_tlast;

    int  fail_count;
    int  pending;
    int  edges_seen;
    int  tours_built;
    int  points_sent;
    int  cycles;
    bit  tx_calm;
    bit  rx_calm;
    bit  hold_rx;

    greedy_path_merge_tour u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    greedy_path_merge_tour_chk u_chk (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast),
        .fail_count  (fail_count),
        .pending     (pending),
        .edges_seen  (edges_seen),
        .tours_built (tours_built)
    );

    initial aclk = 1'b0;
    always #2 aclk = ~aclk;

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // result side: random stalls, plus one long hold-off on request
    initial begin
        int gap;
        m_tready = 1'b0;
        @(posedge aclk iff aresetn);
        forever begin
            gap = rx_calm ? 0 : $urandom_range(0, 14);
            if (hold_rx) begin
                gap     = LONG_HOLD;
                hold_rx = 1'b0;
            end
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
        end
    end

    task automatic send_point(input logic [15:0] x, input logic [15:0] y, input logic last);
        int gap;
        gap = tx_calm ? 0 : $urandom_range(0, 14);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {y, x};
        s_tlast  <= last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        points_sent++;
    endtask

    // one set of points ending in tlast; style picks full range, tight cluster or duplicates
    task automatic send_set(input int count);
        int          style;
        logic [15:0] x;
        logic [15:0] y;
        style   = $urandom_range(0, 3);
        tx_calm = ($urandom_range(0, 3) == 0);
        rx_calm = ($urandom_range(0, 3) == 0);
        for (int p = 1; p <= count; p++) begin
            case (style)
                0, 1: begin
                    x = 16'($urandom);
                    y = 16'($urandom);
                end
                2: begin
                    x = 16'($urandom_range(0, 3)) - 16'd2;
                    y = 16'($urandom_range(0, 3)) - 16'd2;
                end
                default: begin
                    x = $urandom_range(0, 1) ? 16'h8000 : 16'h7fff;
                    y = $urandom_range(0, 1) ? 16'h8000 : 16'h7fff;
                end
            endcase
            send_point(x, y, p == count);
        end
    endtask

    initial begin
        cycles      = 0;
        points_sent = 0;
        tx_calm     = 1'b0;
        rx_calm     = 1'b0;
        hold_rx     = 1'b0;
        aresetn     = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tlast     = 1'b0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // single point, then the two opposite corners for the longest edge
        send_point(16'h0000, 16'h0000, 1'b1);
        send_point(16'h8000, 16'h8000, 1'b0);
        send_point(16'h7fff, 16'h7fff, 1'b1);
        // collinear and equally spaced points give tied pair lengths
        send_point(16'd0, 16'd0, 1'b0);
        send_point(16'd1, 16'd0, 1'b0);
        send_point(16'd2, 16'd0, 1'b1);
        // all points identical
        for (int p = 0; p < 4; p++) send_point(16'd5, 16'hfffb, p == 3);
        // square corners plus its center
        send_point(16'd10, 16'd10, 1'b0);
        send_point(16'hfff6, 16'd10, 1'b0);
        send_point(16'hfff6, 16'hfff6, 1'b0);
        send_point(16'd10, 16'hfff6, 1'b0);
        send_point(16'd0, 16'd0, 1'b1);

        hold_rx = 1'b1;
        send_set(6);
        send_set(3);
        send_set(MAX_POINTS);
        // two points past a full store are dropped
        send_set(MAX_POINTS + 2);
        while (points_sent < 250) send_set($urandom_range(1, 10));
        s_tvalid <= 1'b0;
        s_tlast  <= 1'b0;

        // let the scoreboard see the final transfer before polling it
        repeat (2) @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (300) @(posedge aclk);
        $display("run covered %0d points in %0d tours, %0d edges checked",
                 points_sent, tours_built, edges_seen);
        $display("tours ranged from a single point to an overfull store, with long output stall");
        if (fail_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
